[hdl/rtty_baudot_deframer_defines.svh]
// assertion helpers for the rtty deframer
`ifndef RTTY_BAUDOT_DEFRAMER_DEFINES_SVH
`define RTTY_BAUDOT_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define RBD_ASSERT_SAME(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rtty deframer check failed");

// next-cycle implication
`define RBD_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rtty deframer check failed");

`endif

[hdl/rbd_pkg.sv]
package rbd_pkg;

  localparam int WIN_W = 15;

  localparam logic [1:0] STOP_1   = 2'd0;
  localparam logic [1:0] STOP_1P5 = 2'd1;
  localparam logic [1:0] STOP_2   = 2'd2;

  localparam logic [1:0] LINK_NONE    = 2'd0;
  localparam logic [1:0] LINK_HUNT    = 2'd1;
  localparam logic [1:0] LINK_CONFIRM = 2'd2;
  localparam logic [1:0] LINK_DATA    = 2'd3;

  localparam logic CFG_STOP_MODE = 1'b0;
  localparam logic CFG_INVERT    = 1'b1;

  localparam logic [4:0] LTRS_CODE = 5'd31;
  localparam logic [4:0] FIGS_CODE = 5'd27;

  localparam logic [6:0] LTRS_TAB [0:31] = '{
    7'd0,  7'd69, 7'd10, 7'd65, 7'd32, 7'd83, 7'd73, 7'd85,
    7'd13, 7'd68, 7'd82, 7'd74, 7'd78, 7'd70, 7'd67, 7'd75,
    7'd84, 7'd90, 7'd76, 7'd87, 7'd72, 7'd89, 7'd80, 7'd81,
    7'd79, 7'd66, 7'd71, 7'd0,  7'd77, 7'd88, 7'd86, 7'd0
  };

  localparam logic [6:0] FIGS_TAB [0:31] = '{
    7'd0,  7'd51, 7'd10, 7'd45, 7'd32, 7'd7,  7'd56, 7'd55,
    7'd13, 7'd36, 7'd52, 7'd39, 7'd44, 7'd33, 7'd58, 7'd40,
    7'd53, 7'd34, 7'd41, 7'd50, 7'd35, 7'd54, 7'd48, 7'd49,
    7'd57, 7'd63, 7'd38, 7'd0,  7'd46, 7'd47, 7'd59, 7'd0
  };

  typedef struct packed {
    logic [1:0] stop_mode;
    logic       invert_bit;
  } rbd_cfg_t;

  typedef struct packed {
    logic       char_valid;
    logic [6:0] ascii_char;
    logic [1:0] link_state;
  } rbd_res_t;

  // one-code delay line with shift state
  typedef struct packed {
    logic [4:0] held;
    logic       none_held;
    logic       figs;
  } rbd_dly_t;

  typedef struct packed {
    rbd_dly_t   st;
    logic [6:0] ch;
  } rbd_dec_t;

  function automatic logic [3:0] frame_len(logic [1:0] mode);
    logic [3:0] len;
    case (mode)
      STOP_1P5: len = 4'd15;
      STOP_2:   len = 4'd8;
      default:  len = 4'd7;
    endcase
    return len;
  endfunction

  function automatic logic [WIN_W-1:0] shift_in(logic [WIN_W-1:0] w, logic b,
                                                logic [1:0] mode);
    logic [3:0] pos;
    pos = frame_len(mode) - 4'd1;
    return (w >> 1) | (WIN_W'(b) << pos);
  endfunction

  function automatic logic frame_ok(logic [1:0] mode, logic [WIN_W-1:0] w);
    logic ok;
    ok = 1'b1;
    if (mode == STOP_1P5) begin
      if (w[1:0] != 2'b00) ok = 1'b0;
      for (int i = 0; i < 5; i++) begin
        if (w[2*i+2] != w[2*i+3]) ok = 1'b0;
      end
      if (w[14:12] != 3'b111) ok = 1'b0;
    end else begin
      if (w[0]) ok = 1'b0;
      if (mode == STOP_2) begin
        if (w[7:6] != 2'b11) ok = 1'b0;
      end else if (!w[6]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic logic [4:0] frame_data(logic [1:0] mode, logic [WIN_W-1:0] w);
    logic [4:0] d;
    if (mode == STOP_1P5) begin
      for (int i = 0; i < 5; i++) begin
        d[i] = w[2*i+2] | w[2*i+3];
      end
    end else begin
      d = w[5:1];
    end
    return d;
  endfunction

  function automatic rbd_dec_t dly_step(rbd_dly_t s, logic [4:0] data);
    rbd_dec_t r;
    r.st = s;
    r.ch = '0;
    if (s.none_held) begin
      r.st.none_held = 1'b0;
    end else if (s.held == LTRS_CODE) begin
      r.st.figs = 1'b0;
    end else if (s.held == FIGS_CODE) begin
      r.st.figs = 1'b1;
    end else begin
      r.ch = s.figs ? FIGS_TAB[s.held] : LTRS_TAB[s.held];
    end
    r.st.held = data;
    return r;
  endfunction

endpackage

[hdl/rbd_cfg.sv]
module rbd_cfg
  import rbd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  logic     wr_index,
  input  logic [1:0] wr_data,
  output rbd_cfg_t cfg
);

  logic [1:0] stop_mode_r;
  logic       invert_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_mode_r <= STOP_1P5;
      invert_r    <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_STOP_MODE: stop_mode_r <= wr_data;
        CFG_INVERT:    invert_r    <= wr_data[0];
        default:       ;
      endcase
    end
  end

  assign cfg.stop_mode  = stop_mode_r;
  assign cfg.invert_bit = invert_r;

endmodule

[hdl/rbd_framer.sv]
module rbd_framer
  import rbd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step_en,
  input  logic     bit_value,
  input  logic     signal_present,
  input  rbd_cfg_t cfg,
  output rbd_res_t res
);

  typedef enum logic [1:0] {
    ST_NONE    = LINK_NONE,
    ST_HUNT    = LINK_HUNT,
    ST_CONFIRM = LINK_CONFIRM,
    ST_DATA    = LINK_DATA
  } state_t;

  state_t           state_r, state_nxt;
  logic [WIN_W-1:0] win_r, win_nxt;
  logic [WIN_W-1:0] sync_r, sync_nxt;
  logic [3:0]       taken_r, taken_nxt;
  logic             await_r, await_nxt;
  logic             resync_r, resync_nxt;
  rbd_dly_t         dly_r, dly_nxt;
  logic [6:0]       ch;
  logic             b;
  rbd_dec_t         d1, d2;

  always_comb begin
    b          = bit_value ^ cfg.invert_bit;
    state_nxt  = state_r;
    win_nxt    = win_r;
    sync_nxt   = sync_r;
    taken_nxt  = taken_r;
    await_nxt  = await_r;
    resync_nxt = resync_r;
    dly_nxt    = dly_r;
    ch         = '0;
    d1         = '0;
    d2         = '0;

    // signal loss / gain
    if (!signal_present) begin
      state_nxt = ST_NONE;
    end else if (state_nxt == ST_NONE) begin
      resync_nxt = 1'b1;
    end

    if (resync_nxt) begin
      taken_nxt  = '0;
      win_nxt    = '0;
      sync_nxt   = '0;
      dly_nxt    = '{held: 5'd0, none_held: 1'b1, figs: 1'b0};
      state_nxt  = ST_HUNT;
      resync_nxt = 1'b0;
    end

    case (state_nxt)
      ST_HUNT: begin
        win_nxt = shift_in(win_nxt, b, cfg.stop_mode);
        if (frame_ok(cfg.stop_mode, win_nxt)) begin
          sync_nxt  = win_nxt;
          taken_nxt = '0;
          win_nxt   = '0;
          state_nxt = ST_CONFIRM;
          await_nxt = 1'b1;
        end
      end
      ST_CONFIRM, ST_DATA: begin
        // in 1.5-stop mode the mark idle before a start bit is skipped
        if (!(cfg.stop_mode == STOP_1P5 && await_nxt && b)) begin
          await_nxt = 1'b0;
          win_nxt   = shift_in(win_nxt, b, cfg.stop_mode);
          taken_nxt = taken_nxt + 4'd1;
          if (taken_nxt >= frame_len(cfg.stop_mode)) begin
            if (state_nxt == ST_CONFIRM) begin
              if (frame_ok(cfg.stop_mode, win_nxt)) begin
                d1        = dly_step(dly_nxt, frame_data(cfg.stop_mode, sync_nxt));
                d2        = dly_step(d1.st, frame_data(cfg.stop_mode, win_nxt));
                dly_nxt   = d2.st;
                ch        = (d2.ch != '0) ? d2.ch : d1.ch;
                state_nxt = ST_DATA;
              end else begin
                resync_nxt = 1'b1;
              end
            end else begin
              d1      = dly_step(dly_nxt, frame_data(cfg.stop_mode, win_nxt));
              dly_nxt = d1.st;
              ch      = d1.ch;
            end
            win_nxt   = '0;
            taken_nxt = '0;
            await_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_NONE;
      win_r    <= '0;
      sync_r   <= '0;
      taken_r  <= '0;
      await_r  <= 1'b0;
      resync_r <= 1'b0;
      dly_r    <= '{held: 5'd0, none_held: 1'b1, figs: 1'b0};
    end else if (step_en) begin
      state_r  <= state_nxt;
      win_r    <= win_nxt;
      sync_r   <= sync_nxt;
      taken_r  <= taken_nxt;
      await_r  <= await_nxt;
      resync_r <= resync_nxt;
      dly_r    <= dly_nxt;
    end
  end

  assign res.char_valid = (ch != '0);
  assign res.ascii_char = ch;
  assign res.link_state = state_nxt;

endmodule

[hdl/rtty_baudot_deframer.sv]
// path: an accepted input beat is registered in the input stage, then in the result stage, before out_valid
// throughput: one beat per cycle while out_ready allows, limited by the single framer update step
// each input beat yields exactly one result beat
// reset (rst_n low, synchronous): framer to no signal, letters shift, empty code delay,
// stop_mode to 1.5-stop doubled rate, invert_bit off, both pipeline stages empty
module rtty_baudot_deframer
  import rbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_bit_value,
  input  logic       in_signal_present,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_char_valid,
  output logic [6:0] out_ascii_char,
  output logic [1:0] out_link_state,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [1:0] cfg_data
);

`include "rtty_baudot_deframer_defines.svh"

  rbd_cfg_t cfg;
  rbd_res_t res;

  // input stage
  logic     s1_valid_r;
  logic     s1_bit_r;
  logic     s1_sig_r;

  // result stage
  logic     out_valid_r;
  rbd_res_t out_res_r;

  logic     advance;
  logic     step_en;

  // result register frees up when empty or being taken this cycle
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign step_en  = s1_valid_r && advance;

  // registers always writable; config must only be changed while idle, which the block itself does not enforce
  assign cfg_ready = 1'b1;

  rbd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // payload of the input stage, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_bit_r <= in_bit_value;
      s1_sig_r <= in_signal_present;
    end
  end

  // framer state advances once per beat leaving the input stage
  rbd_framer u_framer (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (step_en),
    .bit_value      (s1_bit_r),
    .signal_present (s1_sig_r),
    .cfg            (cfg),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char_valid = out_res_r.char_valid;
  assign out_ascii_char = out_res_r.ascii_char;
  assign out_link_state = out_res_r.link_state;

  // a character only ever comes out of a locked framer
  `RBD_ASSERT_SAME(a_char_needs_lock, clk, rst_n, out_valid_r && out_res_r.char_valid, out_res_r.link_state == LINK_DATA)
  // no character means a zero code on the bus
  `RBD_ASSERT_SAME(a_idle_char_zero, clk, rst_n, out_valid_r && !out_res_r.char_valid, out_res_r.ascii_char == 7'd0)
  // every framer step lands in the result register on the next edge
  `RBD_ASSERT_NEXT(a_step_reaches_out, clk, rst_n, step_en, out_valid_r)

endmodule
